// ===== rtl/matrix4_inverse_top_macros.svh =====
// Assertion macros for the matrix4_inverse block.
// Taken in by the top level; empty when SYNTH is defined.
`ifndef MATRIX4_INVERSE_TOP_MACROS_SVH
`define MATRIX4_INVERSE_TOP_MACROS_SVH
`ifndef SYNTH
`define MI4_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("matrix4_inverse_top: check failed");
`define MI4_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("matrix4_inverse_top: reset check failed");
`else
`define MI4_ASSERT(lbl, prop)
`define MI4_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/mi4_pkg.sv =====
// Shared widths, codes and the cofactor micro-op decoder for matrix4_inverse.
// No dependencies.
package mi4_pkg;

  localparam int ELEM_W = 32;
  localparam int COF_W  = 98;   // signed cofactor, |C| < 2^96
  localparam int ACC_W  = 136;  // accumulators and determinant, |D| < 2^129

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SCALE = 2'd1;
  localparam logic [1:0] ST_DET   = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef enum logic [1:0] {SRC_ELEM, SRC_T, SRC_D} mac_src_t;
  typedef enum logic [1:0] {DST_T, DST_D, DST_DET} mac_dst_t;

  typedef struct packed {
    logic     ld_y;
    logic     clr;
    logic     ld_x;
    logic     step;
    logic     last_bit;
    logic     sub;
    mac_src_t src;
    mac_dst_t dst;
  } mac_ctrl_t;

  typedef struct packed {
    logic [3:0] a_addr;
    logic [3:0] b_addr;
    mac_src_t   src;
    mac_dst_t   dst;
    logic       sub;
    logic       clr;
  } op_t;

  // index i of the three rows/columns left once x is removed
  function automatic logic [1:0] skip(input logic [1:0] i, input logic [1:0] x);
    return (i < x) ? i : i + 2'd1;
  endfunction

  // op j of cofactor k: three groups of (two minor products, one coefficient product),
  // then for the first row one product into the determinant
  function automatic op_t op_decode(input logic [3:0] k, input logic [3:0] j);
    op_t o;
    logic [1:0] r, c, r0, r1, r2, c0, c1, c2, p, q, cf, g, s;
    logic gneg;
    r  = k[3:2];
    c  = k[1:0];
    r0 = skip(2'd0, r);
    r1 = skip(2'd1, r);
    r2 = skip(2'd2, r);
    c0 = skip(2'd0, c);
    c1 = skip(2'd1, c);
    c2 = skip(2'd2, c);
    unique case (j)
      4'd0: begin g = 2'd0; s = 2'd0; end
      4'd1: begin g = 2'd0; s = 2'd1; end
      4'd2: begin g = 2'd0; s = 2'd2; end
      4'd3: begin g = 2'd1; s = 2'd0; end
      4'd4: begin g = 2'd1; s = 2'd1; end
      4'd5: begin g = 2'd1; s = 2'd2; end
      4'd6: begin g = 2'd2; s = 2'd0; end
      4'd7: begin g = 2'd2; s = 2'd1; end
      4'd8: begin g = 2'd2; s = 2'd2; end
      default: begin g = 2'd3; s = 2'd3; end
    endcase
    unique case (g)
      2'd0: begin p = c1; q = c2; cf = c0; gneg = 1'b0; end
      2'd1: begin p = c0; q = c2; cf = c1; gneg = 1'b1; end
      default: begin p = c0; q = c1; cf = c2; gneg = 1'b0; end
    endcase
    o.a_addr = 4'd0;
    o.b_addr = 4'd0;
    o.src    = SRC_ELEM;
    o.dst    = DST_T;
    o.sub    = 1'b0;
    o.clr    = 1'b0;
    unique case (s)
      2'd0: begin
        o.a_addr = {r1, p};
        o.b_addr = {r2, q};
        o.clr    = 1'b1;
      end
      2'd1: begin
        o.a_addr = {r1, q};
        o.b_addr = {r2, p};
        o.sub    = 1'b1;
      end
      2'd2: begin
        o.a_addr = {r0, cf};
        o.src    = SRC_T;
        o.dst    = DST_D;
        o.sub    = gneg ^ r[0] ^ c[0];
        o.clr    = (g == 2'd0);
      end
      default: begin
        o.a_addr = {2'd0, c};
        o.src    = SRC_D;
        o.dst    = DST_DET;
        o.clr    = (k == 4'd0);
      end
    endcase
    return o;
  endfunction

endpackage

// ===== rtl/mi4_emem.sv =====
// Element store: sixteen 32-bit entries, one write and one registered read port.
// Uses mi4_pkg widths.
module mi4_emem (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [3:0]                  wr_addr,
  input  logic [mi4_pkg::ELEM_W-1:0]  wr_data,
  input  logic [3:0]                  rd_addr,
  output logic [mi4_pkg::ELEM_W-1:0]  rd_data
);

  logic [mi4_pkg::ELEM_W-1:0] mem_r [16];
  logic [mi4_pkg::ELEM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/mi4_mac.sv =====
// Shared bit-serial signed multiply-accumulate unit with the minor, cofactor and
// determinant accumulators. Uses mi4_pkg.
module mi4_mac (
  input  logic                        clk,
  input  mi4_pkg::mac_ctrl_t          ctrl,
  input  logic [mi4_pkg::ELEM_W-1:0]  elem,
  output logic [mi4_pkg::COF_W-1:0]   cof,
  output logic [mi4_pkg::ACC_W-1:0]   det
);

  localparam int AW = mi4_pkg::ACC_W;
  localparam int EW = mi4_pkg::ELEM_W;

  logic [EW-1:0] x_r;
  logic [AW-1:0] y_r, t_r, d_r, det_r;
  logic [AW-1:0] acc_in, addend, sum, y_src;
  logic          sub_eff;

  // the sign bit of the multiplier weighs -2^31
  assign sub_eff = ctrl.sub ^ ctrl.last_bit;
  assign addend  = sub_eff ? ~y_r : y_r;

  always_comb begin
    unique case (ctrl.dst)
      mi4_pkg::DST_T:   acc_in = t_r;
      mi4_pkg::DST_D:   acc_in = d_r;
      default:          acc_in = det_r;
    endcase
    unique case (ctrl.src)
      mi4_pkg::SRC_ELEM: y_src = {{(AW-EW){elem[EW-1]}}, elem};
      mi4_pkg::SRC_T:    y_src = t_r;
      default:           y_src = d_r;
    endcase
  end

  assign sum = acc_in + addend + AW'(sub_eff);

  always_ff @(posedge clk) begin
    if (ctrl.ld_y) begin
      y_r <= y_src;
      if (ctrl.clr) begin
        unique case (ctrl.dst)
          mi4_pkg::DST_T: t_r   <= '0;
          mi4_pkg::DST_D: d_r   <= '0;
          default:        det_r <= '0;
        endcase
      end
    end
    if (ctrl.ld_x) begin
      x_r <= elem;
    end
    if (ctrl.step) begin
      if (x_r[0]) begin
        unique case (ctrl.dst)
          mi4_pkg::DST_T: t_r   <= sum;
          mi4_pkg::DST_D: d_r   <= sum;
          default:        det_r <= sum;
        endcase
      end
      y_r <= {y_r[AW-2:0], 1'b0};
      x_r <= {1'b0, x_r[EW-1:1]};
    end
  end

  assign cof = d_r[mi4_pkg::COF_W-1:0];
  assign det = det_r;

endmodule

// ===== rtl/mi4_div.sv =====
// Restoring divider: |C| * 2^(2F) / |D|, one quotient bit a cycle, with signed
// saturation to 32 bits. Uses mi4_pkg.
module mi4_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mi4_pkg::COF_W-1:0]   cof,
  input  logic [mi4_pkg::ACC_W-1:0]   det,
  output logic                        done,
  output logic [mi4_pkg::ELEM_W-1:0]  quot,
  output logic                        sat
);

  localparam int CW    = mi4_pkg::COF_W;
  localparam int AW    = mi4_pkg::ACC_W;
  localparam int EW    = mi4_pkg::ELEM_W;
  localparam int NUM_W = CW + 2 * FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] n_r;
  logic [AW-1:0]    rem_r, den_r, rem_sh;
  logic [AW:0]      diff;
  logic [EW-1:0]    q_r, lim;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r, ovf_r, neg_r, ge, over;
  logic [CW-1:0]    mag;

  assign mag    = cof[CW-1] ? (~cof + CW'(1)) : cof;
  assign rem_sh = {rem_r[AW-2:0], n_r[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, den_r};
  assign ge     = !diff[AW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= NUM_W'(mag) << (2 * FRAC_BITS);
      den_r <= det[AW-1] ? (~det + AW'(1)) : det;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
      neg_r <= cof[CW-1] ^ det[AW-1];
      cnt_r <= CNT_W'(NUM_W - 1);
    end else if (busy_r) begin
      rem_r <= ge ? diff[AW-1:0] : rem_sh;
      q_r   <= {q_r[EW-2:0], ge};
      // a one leaving the top of the quotient register means it cannot fit
      if (q_r[EW-1]) begin
        ovf_r <= 1'b1;
      end
      n_r   <= {n_r[NUM_W-2:0], 1'b0};
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign lim  = neg_r ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
  assign over = ovf_r || (q_r > lim);
  assign quot = over ? lim : (neg_r ? (~q_r + EW'(1)) : q_r);
  assign sat  = over;
  assign done = done_r;

endmodule

// ===== rtl/matrix4_inverse_top.sv =====
// Channel   | Dir | Ports                               | Item
// in_       | in  | in_tvalid/in_tready/in_tdata        | one Q16.16 element, row-major
// out_      | out | out_tvalid/out_tready/out_tdata,    | one inverse element with
//           |     | out_tuser, out_tlast                | status and last-of-run flag
// cfg_      | in  | cfg_wr_en/cfg_wr_data               | zero-scale tolerance
//
// Elements 1..15 are taken one a cycle. After the sixteenth the block is busy:
// 148 serial products (32-bit shift-add multiplier shared by all cofactors and the
// determinant), then per result one restoring division. Identity runs skip the
// divisions. Reset (synchronous, rst_n low) clears counters, the tolerance and the
// output valid flag. A stalled output holds the sequencer in its emit state.
// Depends on mi4_pkg, mi4_emem, mi4_mac, mi4_div and the assertion macro header.
`include "matrix4_inverse_top_macros.svh"
module matrix4_inverse_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // [31:0] element_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [31:0] inverse_element
  output logic [1:0]  out_tuser,    // [1:0] status_code
  output logic        out_tlast,    // last_element
  input  logic        cfg_wr_en,
  input  logic [30:0] cfg_wr_data   // zero_scale_tolerance
);

  localparam int EW = mi4_pkg::ELEM_W;
  localparam int CW = mi4_pkg::COF_W;
  localparam int AW = mi4_pkg::ACC_W;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_RDB   = 11'b000_0000_0010,
    S_RDA   = 11'b000_0000_0100,
    S_LDX   = 11'b000_0000_1000,
    S_MUL   = 11'b000_0001_0000,
    S_COFW  = 11'b000_0010_0000,
    S_CHK   = 11'b000_0100_0000,
    S_DRD   = 11'b000_1000_0000,
    S_DLD   = 11'b001_0000_0000,
    S_DWAIT = 11'b010_0000_0000,
    S_EMIT  = 11'b100_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [3:0]        load_cnt_r, load_cnt_nxt;
  logic [3:0]        k_r, k_nxt, j_r, j_nxt;
  logic [4:0]        bit_cnt_r, bit_cnt_nxt;
  logic              id_mode_r, id_mode_nxt;
  logic [1:0]        id_stat_r, id_stat_nxt;
  logic [30:0]       tol_r;
  logic [EW-1:0]     max_r, mag;
  logic              in_acc, in_block, scale_low, emit_go;
  logic              out_tvalid_r, out_tlast_r;
  logic [EW-1:0]     out_data_r, ident_val, emit_val;
  logic [1:0]        out_user_r, emit_stat;
  mi4_pkg::op_t      op;
  mi4_pkg::mac_ctrl_t mac_ctrl;
  logic [3:0]        rd_addr;
  logic [EW-1:0]     elem_rd;
  logic [CW-1:0]     cof_w, cof_rd_r;
  logic [AW-1:0]     det_w;
  logic [CW-1:0]     cof_mem_r [16];
  logic              div_done, div_sat;
  logic [EW-1:0]     div_quot;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign op        = mi4_pkg::op_decode(k_r, j_r);
  assign rd_addr   = (state_r == S_RDB) ? op.b_addr : op.a_addr;

  // zero-scale check: largest magnitude in the upper-left 3x3 block
  assign mag       = in_tdata[EW-1] ? (~in_tdata + EW'(1)) : in_tdata;
  assign in_block  = (load_cnt_r[3:2] != 2'd3) && (load_cnt_r[1:0] != 2'd3);
  assign scale_low = (max_r <= {1'b0, tol_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (load_cnt_r == 4'd0) begin
        max_r <= mag;
      end else if (in_block && (mag > max_r)) begin
        max_r <= mag;
      end
    end
  end

  mi4_emem u_emem (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (load_cnt_r),
    .wr_data (in_tdata),
    .rd_addr (rd_addr),
    .rd_data (elem_rd)
  );

  always_comb begin
    mac_ctrl          = '0;
    mac_ctrl.ld_y     = (state_r == S_RDA);
    mac_ctrl.clr      = (state_r == S_RDA) && op.clr;
    mac_ctrl.ld_x     = (state_r == S_LDX);
    mac_ctrl.step     = (state_r == S_MUL);
    mac_ctrl.last_bit = (bit_cnt_r == 5'd31);
    mac_ctrl.sub      = op.sub;
    mac_ctrl.src      = op.src;
    mac_ctrl.dst      = op.dst;
  end

  mi4_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .elem (elem_rd),
    .cof  (cof_w),
    .det  (det_w)
  );

  // cofactor store, read transposed for the adjugate
  always_ff @(posedge clk) begin
    if (state_r == S_COFW) begin
      cof_mem_r[k_r] <= cof_w;
    end
    cof_rd_r <= cof_mem_r[{k_r[1:0], k_r[3:2]}];
  end

  mi4_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DLD),
    .cof   (cof_rd_r),
    .det   (det_w),
    .done  (div_done),
    .quot  (div_quot),
    .sat   (div_sat)
  );

  assign emit_go   = (state_r == S_EMIT) && (!out_tvalid_r || out_tready);
  assign ident_val = (k_r[3:2] == k_r[1:0]) ? (EW'(1) << FRAC_BITS) : '0;
  assign emit_val  = id_mode_r ? ident_val : div_quot;
  assign emit_stat = id_mode_r ? id_stat_r : (div_sat ? mi4_pkg::ST_SAT : mi4_pkg::ST_OK);

  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    k_nxt        = k_r;
    j_nxt        = j_r;
    bit_cnt_nxt  = bit_cnt_r;
    id_mode_nxt  = id_mode_r;
    id_stat_nxt  = id_stat_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          load_cnt_nxt = load_cnt_r + 4'd1;
          if (load_cnt_r == 4'd15) begin
            k_nxt = 4'd0;
            j_nxt = 4'd0;
            if (scale_low) begin
              id_mode_nxt = 1'b1;
              id_stat_nxt = mi4_pkg::ST_SCALE;
              state_nxt   = S_EMIT;
            end else begin
              state_nxt = S_RDB;
            end
          end
        end
      end
      S_RDB: state_nxt = S_RDA;
      S_RDA: state_nxt = S_LDX;
      S_LDX: begin
        bit_cnt_nxt = 5'd0;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        bit_cnt_nxt = bit_cnt_r + 5'd1;
        if (bit_cnt_r == 5'd31) begin
          priority if (j_r == 4'd8) begin
            state_nxt = S_COFW;
          end else if (j_r == 4'd9) begin
            k_nxt     = k_r + 4'd1;
            j_nxt     = 4'd0;
            state_nxt = S_RDB;
          end else begin
            j_nxt     = j_r + 4'd1;
            state_nxt = S_RDB;
          end
        end
      end
      S_COFW: begin
        priority if (k_r[3:2] == 2'd0) begin
          j_nxt     = 4'd9;
          state_nxt = S_RDB;
        end else if (k_r == 4'd15) begin
          state_nxt = S_CHK;
        end else begin
          k_nxt     = k_r + 4'd1;
          j_nxt     = 4'd0;
          state_nxt = S_RDB;
        end
      end
      S_CHK: begin
        k_nxt = 4'd0;
        if (det_w == '0) begin
          id_mode_nxt = 1'b1;
          id_stat_nxt = mi4_pkg::ST_DET;
          state_nxt   = S_EMIT;
        end else begin
          id_mode_nxt = 1'b0;
          state_nxt   = S_DRD;
        end
      end
      S_DRD: state_nxt = S_DLD;
      S_DLD: state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          if (k_r == 4'd15) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 4'd1;
            state_nxt = id_mode_r ? S_EMIT : S_DRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      load_cnt_r <= '0;
      k_r        <= '0;
      j_r        <= '0;
      bit_cnt_r  <= '0;
      id_mode_r  <= 1'b0;
      id_stat_r  <= mi4_pkg::ST_OK;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      k_r        <= k_nxt;
      j_r        <= j_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      id_mode_r  <= id_mode_nxt;
      id_stat_r  <= id_stat_nxt;
    end
  end

  // output register: hold the item until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit_go) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data_r  <= emit_val;
      out_user_r  <= emit_stat;
      out_tlast_r <= (k_r == 4'd15);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_tlast_r;

  `MI4_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE) && !out_tvalid_r)
  `MI4_ASSERT(a_last_leaves, in_acc && (load_cnt_r == 4'd15) |=> !in_tready)
  `MI4_ASSERT(a_div_done, div_done |-> (state_r == S_DWAIT))
  `MI4_ASSERT(a_end_run, emit_go && (k_r == 4'd15) |=> (state_r == S_IDLE) && out_tlast)

endmodule
